/* rtl/core/tps_pkg.sv */
package tps_pkg;

    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 8;
    localparam int LINE_W    = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
    localparam logic [BYTE_W-1:0] CH_FF = 8'd12;

    localparam logic [SLOT_W-1:0] SPOOL_COUNT_RST = 8'd10;
    localparam logic [LINE_W-1:0] LINES_RST       = 10'd66;
    localparam logic [LINE_W-1:0] IDLE_LIMIT_RST  = 10'd60;

    localparam logic OP_BYTE       = 1'b0;
    localparam logic OP_TICK       = 1'b1;
    localparam logic KIND_BYTE     = 1'b0;
    localparam logic KIND_PAGE_END = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPOOL_COUNT    = 2'd0,
        CFG_LINES_PER_PAGE = 2'd1,
        CFG_IDLE_LIMIT     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic [SLOT_W-1:0] spool_slot;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

/* rtl/core/tps_core.sv */
module tps_core
    import tps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 accept,
    input  logic                 opcode,
    input  logic [BYTE_W-1:0]    data_byte,
    output push_t                push
);

    logic [SLOT_W-1:0] spool_count_reg;
    logic [LINE_W-1:0] lines_per_page_reg;
    logic [LINE_W-1:0] idle_limit_reg;

    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic [LINE_W-1:0] idle_count_reg, idle_count_next;
    logic              content_reg, content_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              full;
    logic [SLOT_W:0]   slot_inc;
    logic [SLOT_W-1:0] slot_after;
    result_t           end_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spool_count_reg    <= SPOOL_COUNT_RST;
            lines_per_page_reg <= LINES_RST;
            idle_limit_reg     <= IDLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SPOOL_COUNT:    spool_count_reg    <= cfg_wdata[SLOT_W-1:0];
                CFG_LINES_PER_PAGE: lines_per_page_reg <= cfg_wdata[LINE_W-1:0];
                CFG_IDLE_LIMIT:     idle_limit_reg     <= cfg_wdata[LINE_W-1:0];
                default:            ;
            endcase
        end
    end

    assign full       = line_count_reg >= lines_per_page_reg;
    assign slot_inc   = {1'b0, slot_reg} + {{SLOT_W{1'b0}}, 1'b1};
    assign slot_after = (slot_inc >= {1'b0, spool_count_reg}) ? '0 : slot_inc[SLOT_W-1:0];

    always_comb
    begin
        end_res            = '0;
        end_res.kind       = KIND_PAGE_END;
        end_res.spool_slot = slot_reg;

        push            = '0;
        line_count_next = line_count_reg;
        idle_count_next = idle_count_reg;
        content_next    = content_reg;
        slot_next       = slot_reg;

        if (accept)
        begin
            if (opcode == OP_BYTE)
            begin
                if (full)
                begin
                    push.push0      = 1'b1;
                    push.res0       = end_res;
                    line_count_next = '0;
                    idle_count_next = '0;
                    content_next    = 1'b0;
                    slot_next       = slot_after;
                    if (data_byte != CH_FF && data_byte != CH_CR)
                    begin
                        push.push1           = 1'b1;
                        push.res1.kind       = KIND_BYTE;
                        push.res1.out_byte   = data_byte;
                        push.res1.spool_slot = slot_after;
                        content_next         = 1'b1;
                        if (data_byte == CH_LF)
                        begin
                            line_count_next = {{(LINE_W-1){1'b0}}, 1'b1};
                        end
                    end
                end
                else if (data_byte == CH_FF)
                begin
                    push.push0      = 1'b1;
                    push.res0       = end_res;
                    line_count_next = '0;
                    idle_count_next = '0;
                    content_next    = 1'b0;
                    slot_next       = slot_after;
                end
                else if (data_byte != CH_CR)
                begin
                    push.push0           = 1'b1;
                    push.res0.kind       = KIND_BYTE;
                    push.res0.out_byte   = data_byte;
                    push.res0.spool_slot = slot_reg;
                    content_next         = 1'b1;
                    if (data_byte == CH_LF)
                    begin
                        line_count_next = line_count_reg + {{(LINE_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            else if (content_reg)
            begin
                if (full || idle_count_reg >= idle_limit_reg)
                begin
                    push.push0      = 1'b1;
                    push.res0       = end_res;
                    line_count_next = '0;
                    idle_count_next = '0;
                    content_next    = 1'b0;
                    slot_next       = slot_after;
                end
                else
                begin
                    idle_count_next = idle_count_reg + {{(LINE_W-1){1'b0}}, 1'b1};
                end
            end
        end

        // The final result of an item carries the end marker.
        if (push.push1)
        begin
            push.res1.last = 1'b1;
        end
        else
        begin
            push.res0.last = push.push0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            idle_count_reg <= '0;
            content_reg    <= 1'b0;
            slot_reg       <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            idle_count_reg <= idle_count_next;
            content_reg    <= content_next;
            slot_reg       <= slot_next;
        end
    end

endmodule

/* rtl/core/tps_outq.sv */
module tps_outq
    import tps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t            q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic [Q_PTR_W-1:0] wr_ptr_1;
    logic               pop;
    logic [Q_CNT_W-1:0] n_push;

    assign out_valid = count_reg != '0;
    assign out_res   = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Two free entries are needed, as one item may give two results.
    assign room      = count_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign wr_ptr_1  = wr_ptr_reg + {{(Q_PTR_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        n_push      = Q_CNT_W'({1'b0, push.push0} + {1'b0, push.push1});
        wr_ptr_next = wr_ptr_reg + n_push[Q_PTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + {{(Q_PTR_W-1){1'b0}}, 1'b1} : rd_ptr_reg;
        count_next  = count_reg + n_push - {{(Q_CNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            if (push.push0 && wr_ptr_reg == Q_PTR_W'(i))
            begin
                q_reg[i] <= push.res0;
            end
            else if (push.push1 && wr_ptr_1 == Q_PTR_W'(i))
            begin
                q_reg[i] <= push.res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/text_page_splitter_with_timeout.sv */
// Splits a byte stream into pages over a ring of spool slots. Each input beat is
// either a received byte or an idle tick; it gives none, one or two output beats
// (a page end and then a byte written to the next slot), the last of which
// carries tlast. Page state is updated in the cycle the beat is taken, and its
// results wait in a four-entry output queue until the output takes them. A new
// input beat is taken every cycle while the queue holds no more than two beats.
// The sustained rate is one input beat per cycle while each item gives at most
// one result and the output drains one beat per cycle; an item that gives two
// results can stall the input when the queue is already holding beats.
module text_page_splitter_with_timeout
    import tps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // data_byte
    input  logic                 s_axis_tuser,   // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // out_byte, spool_slot
    output logic                 m_axis_tuser,   // kind
    output logic                 m_axis_tlast
);

    push_t   push;
    result_t out_res;
    logic    room;
    logic    accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    tps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .opcode    (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .push      (push)
    );

    tps_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.spool_slot, out_res.out_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
